>>> rtl/core/isv_pkg.sv
// Shared types and constants for the interpolating sample voice.
// Used by the front end, queue, back end and top level; depends on nothing.
package isv_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int FADE_STEPS  = 50;
    localparam int FADE_W      = $clog2(FADE_STEPS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int SCALE_DEN    = 100;
    localparam int SAT_LIMIT    = 32768 * SCALE_DEN;
    localparam int DIV100_SHIFT = 29;
    localparam longint DIV100_MUL = ((64'd1 << DIV100_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
    localparam int DIV5_SHIFT   = 30;
    localparam longint DIV5_MUL   = ((64'd1 << DIV5_SHIFT) + 4) / 5;

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_UPDATE = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_FADE   = 3'd4;
    localparam logic [2:0] MODE_TICK   = 3'd5;
    localparam logic [2:0] MODE_RENDER = 3'd6;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_START  = 3'd1,
        OP_UPDATE = 3'd2,
        OP_STOP   = 3'd3,
        OP_FADE   = 3'd4,
        OP_TICK   = 3'd5,
        OP_RENDER = 3'd6,
        OP_NOP    = 3'd7
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               load_ok;
        logic [15:0]        sample_index;
        logic signed [15:0] sample_value;
        logic [16:0]        sample_count;
        logic [15:0]        rate;
        logic [15:0]        volume;
        logic               loop_enable;
    } item_t;

endpackage

>>> rtl/core/isv_front.sv
// Front end: accepts input words, decodes the mode and holds one word for the queue.
// Depends on isv_pkg.
module isv_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic [15:0]        s_sample_index,
    input  logic signed [15:0] s_sample_value,
    input  logic [16:0]        s_sample_count,
    input  logic [15:0]        s_rate,
    input  logic [15:0]        s_volume,
    input  logic               s_loop_enable,
    output logic               push_valid,
    input  logic               push_ready,
    output isv_pkg::item_t     push_item
);
    import isv_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    item_t item_dec;
    logic  s_fire;

    assign s_ready = !valid_reg || push_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        case (s_mode)
            MODE_LOAD:   item_dec.op = OP_LOAD;
            MODE_START:  item_dec.op = OP_START;
            MODE_UPDATE: item_dec.op = OP_UPDATE;
            MODE_STOP:   item_dec.op = OP_STOP;
            MODE_FADE:   item_dec.op = OP_FADE;
            MODE_TICK:   item_dec.op = OP_TICK;
            MODE_RENDER: item_dec.op = OP_RENDER;
            default:     item_dec.op = OP_NOP;
        endcase
        item_dec.load_ok      = (32'(s_sample_index) < 32'(STORE_DEPTH));
        item_dec.sample_index = s_sample_index;
        item_dec.sample_value = s_sample_value;
        item_dec.sample_count = s_sample_count;
        item_dec.rate         = s_rate;
        item_dec.volume       = s_volume;
        item_dec.loop_enable  = s_loop_enable;
    end

    assign valid_next = s_fire || (valid_reg && !push_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= item_dec;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

>>> rtl/core/isv_queue.sv
// Short queue of decoded words between the front end and the back end.
// Depends on isv_pkg.
module isv_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  isv_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output isv_pkg::item_t pop_item
);
    import isv_pkg::*;

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/isv_back.sv
// Back end: sample store, voice state and the render and tick datapaths.
// Holds the result register. Depends on isv_pkg.
module isv_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  isv_pkg::item_t     pop_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_audio_sample,
    output logic               m_voice_finished,
    output logic [16:0]        m_play_index
);
    import isv_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_READ   = 10'b0000000010,
        ST_INTERP = 10'b0000000100,
        ST_SUM    = 10'b0000001000,
        ST_GAIN   = 10'b0000010000,
        ST_FADE   = 10'b0000100000,
        ST_SCALE  = 10'b0001000000,
        ST_TICK   = 10'b0010000000,
        ST_TDIV   = 10'b0100000000,
        ST_COMMIT = 10'b1000000000
    } state_t;

    function automatic logic voice_done(input logic present, input logic [32:0] pos,
                                        input logic [16:0] len, input logic idle,
                                        input logic [FADE_W-1:0] fc);
        voice_done = !present || (pos > {len, 16'd0}) || (!idle && fc == '0);
    endfunction

    state_t state_reg, state_next;

    logic signed [15:0] store_mem [STORE_DEPTH];

    item_t              item_reg;
    logic               go_reg;
    logic [32:0]        position_reg, position_next;
    logic [16:0]        length_reg, length_next;
    logic               present_reg, present_next;
    logic [23:0]        sr_reg, sr_next;
    logic [15:0]        tr_reg, tr_next;
    logic [15:0]        gain_reg, gain_next;
    logic               looping_reg, looping_next;
    logic [FADE_W-1:0]  fc_reg, fc_next;
    logic               idle_reg, idle_next;

    logic signed [15:0] rd0_reg, rd1_reg;
    logic               ok0_reg, ok1_reg;
    logic [15:0]        frac_reg;
    logic [32:0]        pos_adv_reg;
    logic signed [15:0] d0_reg;
    logic signed [33:0] prod_reg;
    logic signed [15:0] s_reg;
    logic signed [32:0] p_reg;
    logic               neg_reg;
    logic [38:0]        x_reg;
    logic [14:0]        q_reg;
    logic               sat_reg;
    logic [28:0]        tsum_reg;
    logic [23:0]        sr_new_reg;

    logic               m_valid_reg;
    logic signed [15:0] audio_reg;
    logic               finished_reg;
    logic [16:0]        play_index_reg;

    logic               finished_now;
    logic               commit_fire;
    logic [16:0]        cur;
    logic [17:0]        nxt_inc;
    logic [16:0]        nxt;
    logic               in_range;
    logic [33:0]        adv_sum;
    logic [32:0]        pos_sat;
    logic               wrap;
    logic signed [15:0] d0, d1;
    logic signed [16:0] diff;
    logic signed [33:0] acc;
    logic               corr;
    logic signed [17:0] s_full;
    logic               neg;
    logic [31:0]        mag;
    logic [6:0]         fade_k;
    logic [23:0]        y;
    logic [50:0]        qprod;
    logic [54:0]        tprod;
    logic signed [15:0] audio_c;
    logic [15:0]        q16;

    assign finished_now = voice_done(present_reg, position_reg, length_reg, idle_reg, fc_reg);
    assign commit_fire  = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);
    assign pop_ready    = (state_reg == ST_IDLE);

    // Store addressing and the position advance, both taken from the state before the render.
    assign cur      = position_reg[32:16];
    assign nxt_inc  = {1'b0, cur} + 18'd1;
    assign nxt      = (nxt_inc < {1'b0, length_reg}) ? nxt_inc[16:0] : cur;
    assign in_range = (cur < length_reg);
    assign adv_sum  = {1'b0, position_reg} + 34'(sr_reg[23:4]);
    assign pos_sat  = adv_sum[33] ? '1 : adv_sum[32:0];
    assign wrap     = looping_reg &&
                      ((length_reg == '0) || (pos_sat >= {length_reg - 17'd1, 16'd0}));

    assign d0   = ok0_reg ? rd0_reg : 16'sd0;
    assign d1   = ok1_reg ? rd1_reg : 16'sd0;
    assign diff = 17'(d1) - 17'(d0);

    assign acc    = (34'(d0_reg) <<< 16) + prod_reg;
    assign corr   = acc[33] && (acc[15:0] != 16'd0);
    assign s_full = $signed(acc[33:16]) + $signed({17'd0, corr});

    assign neg    = p_reg[32];
    assign mag    = neg ? 32'(-p_reg) : p_reg[31:0];
    assign fade_k = idle_reg ? 7'(SCALE_DEN) : 7'(fc_reg);

    assign y      = x_reg[38:15];
    assign qprod  = 51'(y[21:0]) * 51'(DIV100_MUL);
    assign tprod  = 55'(tsum_reg[28:2]) * 55'(DIV5_MUL);

    assign q16    = {1'b0, q_reg};
    always_comb begin
        if (sat_reg) begin
            audio_c = neg_reg ? 16'sh8000 : 16'sh7FFF;
        end else begin
            audio_c = neg_reg ? $signed(16'(-q16)) : $signed(q16);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    if (pop_item.op == OP_RENDER && !finished_now) begin
                        state_next = ST_READ;
                    end else if (pop_item.op == OP_TICK) begin
                        state_next = ST_TICK;
                    end else begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_READ:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_SUM;
            ST_SUM:    state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_FADE;
            ST_FADE:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_COMMIT;
            ST_TICK:   state_next = ST_TDIV;
            ST_TDIV:   state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (commit_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        position_next = position_reg;
        length_next   = length_reg;
        present_next  = present_reg;
        sr_next       = sr_reg;
        tr_next       = tr_reg;
        gain_next     = gain_reg;
        looping_next  = looping_reg;
        fc_next       = fc_reg;
        idle_next     = idle_reg;
        case (item_reg.op)
            OP_START: begin
                present_next  = 1'b1;
                length_next   = item_reg.sample_count;
                position_next = '0;
                tr_next       = item_reg.rate;
                sr_next       = {item_reg.rate, 8'd0};
                gain_next     = item_reg.volume;
                looping_next  = item_reg.loop_enable;
                idle_next     = 1'b1;
                fc_next       = '0;
            end
            OP_UPDATE: begin
                idle_next    = 1'b1;
                fc_next      = '0;
                looping_next = 1'b1;
                tr_next      = item_reg.rate;
                gain_next    = item_reg.volume;
            end
            OP_STOP: begin
                looping_next = 1'b0;
                idle_next    = 1'b0;
                fc_next      = '0;
            end
            OP_FADE: begin
                if (idle_reg) begin
                    idle_next = 1'b0;
                    fc_next   = FADE_W'(FADE_STEPS);
                end
            end
            OP_TICK: begin
                sr_next = sr_new_reg;
                if (!idle_reg && fc_reg != '0) begin
                    fc_next = fc_reg - 1'b1;
                end
            end
            OP_RENDER: begin
                if (go_reg) begin
                    position_next = pos_adv_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            position_reg <= '0;
            length_reg   <= '0;
            present_reg  <= 1'b0;
            sr_reg       <= 24'h100000;
            tr_reg       <= 16'h1000;
            gain_reg     <= 16'h8000;
            looping_reg  <= 1'b0;
            fc_reg       <= '0;
            idle_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit_fire) begin
                position_reg <= position_next;
                length_reg   <= length_next;
                present_reg  <= present_next;
                sr_reg       <= sr_next;
                tr_reg       <= tr_next;
                gain_reg     <= gain_next;
                looping_reg  <= looping_next;
                fc_reg       <= fc_next;
                idle_reg     <= idle_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && pop_valid) begin
            item_reg <= pop_item;
            go_reg   <= (pop_item.op == OP_RENDER) && !finished_now;
        end
        if (state_reg == ST_READ) begin
            ok0_reg     <= in_range && (32'(cur) < 32'(STORE_DEPTH));
            ok1_reg     <= in_range && (32'(nxt) < 32'(STORE_DEPTH));
            frac_reg    <= position_reg[15:0];
            pos_adv_reg <= wrap ? '0 : pos_sat;
        end
        if (state_reg == ST_INTERP) begin
            d0_reg   <= d0;
            prod_reg <= 34'(diff) * 34'($signed({1'b0, frac_reg}));
        end
        if (state_reg == ST_SUM) begin
            s_reg <= s_full[15:0];
        end
        if (state_reg == ST_GAIN) begin
            p_reg <= 33'(s_reg) * $signed({17'd0, gain_reg});
        end
        if (state_reg == ST_FADE) begin
            neg_reg <= neg;
            x_reg   <= 39'(mag) * 39'(fade_k);
        end
        if (state_reg == ST_SCALE) begin
            sat_reg <= (y >= 24'(SAT_LIMIT));
            q_reg   <= qprod[DIV100_SHIFT +: 15];
        end
        if (state_reg == ST_TICK) begin
            tsum_reg <= 29'(sr_reg) * 29'd19 + {5'd0, tr_reg, 8'd0};
        end
        if (state_reg == ST_TDIV) begin
            sr_new_reg <= tprod[DIV5_SHIFT +: 24];
        end
        if (commit_fire) begin
            audio_reg      <= (item_reg.op == OP_RENDER && go_reg) ? audio_c : 16'sd0;
            finished_reg   <= voice_done(present_next, position_next, length_next,
                                         idle_next, fc_next);
            play_index_reg <= position_next[32:16];
        end
    end

    // Sample store: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (commit_fire && item_reg.op == OP_LOAD && item_reg.load_ok) begin
            store_mem[STORE_AW'(item_reg.sample_index)] <= item_reg.sample_value;
        end
        if (state_reg == ST_READ) begin
            rd0_reg <= store_mem[STORE_AW'(cur)];
            rd1_reg <= store_mem[STORE_AW'(nxt)];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_audio_sample   = audio_reg;
    assign m_voice_finished = finished_reg;
    assign m_play_index     = play_index_reg;

endmodule

>>> rtl/core/interpolating_sample_voice_top.sv
// Top level of the interpolating sample voice: front end, word queue and back end.
// Depends on isv_pkg, isv_front, isv_queue and isv_back.
//
//   Channel | Ports | Direction | Word
//   input   | s_*   | in        | mode, sample_index, sample_value, sample_count, rate,
//           |       |           | volume, loop_enable
//   result  | m_*   | out       | audio_sample, voice_finished, play_index
//
// The back end takes one word at a time: a render of a playing voice passes through store
// read, interpolation multiply, sum, gain multiply, fade multiply, reciprocal divide and
// commit, a tick through the tick sum, its divide and commit, and every other word commits.
// The front register and a two-word queue keep accepting while the back end works.
// Reset clears all control state and the voice registers; the sample store is not cleared.
// A stalled result holds in the output register and the back end waits at its commit step.
module interpolating_sample_voice_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic [15:0]        s_sample_index,
    input  logic signed [15:0] s_sample_value,
    input  logic [16:0]        s_sample_count,
    input  logic [15:0]        s_rate,
    input  logic [15:0]        s_volume,
    input  logic               s_loop_enable,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_audio_sample,
    output logic               m_voice_finished,
    output logic [16:0]        m_play_index
);
    import isv_pkg::*;

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    isv_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_sample_index (s_sample_index),
        .s_sample_value (s_sample_value),
        .s_sample_count (s_sample_count),
        .s_rate         (s_rate),
        .s_volume       (s_volume),
        .s_loop_enable  (s_loop_enable),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    isv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    isv_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_audio_sample   (m_audio_sample),
        .m_voice_finished (m_voice_finished),
        .m_play_index     (m_play_index)
    );

endmodule

>>> rtl/core/isv_checker.sv
// Port-level checks for the interpolating sample voice, bound to the top level.
// Depends on interpolating_sample_voice_top.
module isv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_audio_sample,
    input logic               m_voice_finished,
    input logic [16:0]        m_play_index
);
    // Words inside the block: front register, two queue slots, back end and output register.
    localparam logic [3:0] MAX_HELD = 4'd5;

    logic [3:0] held_reg, held_next;
    logic       in_fire, out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    always_comb begin
        held_next = held_reg;
        if (in_fire && !out_fire) begin
            held_next = held_reg + 4'd1;
        end else if (out_fire && !in_fire) begin
            held_next = held_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 4'd0;
        end else begin
            held_reg <= held_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_audio_sample) &&
            $stable(m_voice_finished) && $stable(m_play_index))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> held_reg != 4'd0)
        else $error("result word shown with no input word outstanding");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= MAX_HELD)
        else $error("more words outstanding than the block can hold");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind interpolating_sample_voice_top isv_checker u_isv_checker (.*);
